// File: rtl/bcgm_pkg.sv
`timescale 1ns / 1ps
package bcgm_pkg;

	localparam int MAX_GESTURE   = 8;
	localparam int GESTURE_COUNT = 4;

	localparam int HW = (MAX_GESTURE > 1) ? $clog2(MAX_GESTURE) : 1;
	localparam int GW = (GESTURE_COUNT > 1) ? $clog2(GESTURE_COUNT) : 1;
	localparam int SW = HW + 2;

	localparam int COORD_W    = 16;
	localparam int SIZE_W     = 15;
	localparam int TIME_W     = 32;
	localparam int DIFF_W     = 18;
	localparam int BORDER_W   = 2;
	localparam int MATCH_W    = 4;
	localparam int PAT_W      = 21;
	localparam int LEN_W      = 4;
	localparam int LEN_LO     = 16;
	localparam int DIR_BIT    = 20;
	localparam int CODES_W    = 16;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 32;
	localparam int CFG_NUM_REGS = 8;
	localparam int IN_TDATA_W  = 128;
	localparam int IN_TUSER_W  = 1;
	localparam int OUT_TDATA_W = 8;

	localparam logic [BORDER_W-1:0] BORDER_TOP    = 2'd0;
	localparam logic [BORDER_W-1:0] BORDER_BOTTOM = 2'd1;
	localparam logic [BORDER_W-1:0] BORDER_RIGHT  = 2'd2;
	localparam logic [BORDER_W-1:0] BORDER_LEFT   = 2'd3;

	localparam logic CFG_KIND_PATTERN = 1'b0;
	localparam logic CFG_KIND_TIMEOUT = 1'b1;

	typedef struct packed {
		logic load_in;
		logic diff;
		logic border;
		logic ginit;
		logic walk;
		logic gend;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic len_ok;
		logic step_last;
		logic gest_last;
	} sts_t;

endpackage

// File: rtl/border_crossing_gesture_matcher_core.sv
`timescale 1ns / 1ps
// Takes one window-frame crossing per request, names the border crossed, records it in an
// eight-entry history ring and returns one result holding the border and a bit for each of
// the four programmed gestures that ends at this crossing. For each gesture in turn, the
// sequencer loads its pattern, walks the history one entry per cycle and records its match
// bit; a gesture with an invalid length is not walked. The block takes no new request until
// the result is loaded. A new request is accepted while the previous result still waits
// in the output register. Configuration writes are accepted in every cycle.
module border_crossing_gesture_matcher_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	// pointer_x, pointer_y, frame_left, frame_top, frame_width, frame_height, event_time
	input  logic [bcgm_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
	// entering
	input  logic [bcgm_pkg::IN_TUSER_W-1:0]      s_axis_tuser,
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	// border, matched
	output logic [bcgm_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [bcgm_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [bcgm_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import bcgm_pkg::*;

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	bcgm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.sts       (sts),
		.cmd       (cmd)
	);

	bcgm_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_data   (s_axis_tdata),
		.in_user   (s_axis_tuser),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_data  (m_axis_tdata)
	);

	a_busy_after_request: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("block accepted a request while still processing one");

	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !$rose(m_axis_tvalid))
		else $error("result appeared directly after a request");

	a_single_command: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load_in, cmd.diff, cmd.border, cmd.ginit, cmd.walk, cmd.gend,
			cmd.out_load}))
		else $error("controller issued more than one command in a cycle");

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!m_axis_tvalid || m_axis_tready))
		else $error("output register overwritten before its result was taken");

endmodule

// File: rtl/bcgm_ctrl.sv
`timescale 1ns / 1ps
module bcgm_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	input  bcgm_pkg::sts_t sts,
	output bcgm_pkg::cmd_t cmd
);
	import bcgm_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_DIFF  = 3'd1;
	localparam logic [2:0] S_BORD  = 3'd2;
	localparam logic [2:0] S_GINIT = 3'd3;
	localparam logic [2:0] S_WALK  = 3'd4;
	localparam logic [2:0] S_GEND  = 3'd5;
	localparam logic [2:0] S_DONE  = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = S_DIFF;
				end
			end
			S_DIFF: begin
				cmd.diff = 1'b1;
				state_d  = S_BORD;
			end
			S_BORD: begin
				cmd.border = 1'b1;
				state_d    = S_GINIT;
			end
			S_GINIT: begin
				cmd.ginit = 1'b1;
				state_d   = sts.len_ok ? S_WALK : S_GEND;
			end
			S_WALK: begin
				cmd.walk = 1'b1;
				if (sts.step_last) begin
					state_d = S_GEND;
				end
			end
			S_GEND: begin
				cmd.gend = 1'b1;
				state_d  = sts.gest_last ? S_DONE : S_GINIT;
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

endmodule

// File: rtl/bcgm_datapath.sv
`timescale 1ns / 1ps
module bcgm_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  bcgm_pkg::cmd_t                      cmd,
	output bcgm_pkg::sts_t                      sts,
	input  logic [bcgm_pkg::IN_TDATA_W-1:0]     in_data,
	input  logic [bcgm_pkg::IN_TUSER_W-1:0]     in_user,
	input  logic                                cfg_we,
	input  logic [bcgm_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [bcgm_pkg::CFG_DATA_W-1:0]     cfg_data,
	output logic [bcgm_pkg::OUT_TDATA_W-1:0]    out_data
);
	import bcgm_pkg::*;

	logic signed [COORD_W-1:0] px_q, py_q, left_q, top_q;
	logic [SIZE_W-1:0]         w_q, h_q;
	logic                      ent_q;
	logic [TIME_W-1:0]         time_q;

	logic signed [DIFF_W-1:0] dx_q, dy_q;
	logic [DIFF_W-1:0]        mid_x, mid_y, ax, ay;
	logic [BORDER_W-1:0]      border_d, border_q;

	logic [HW-1:0]       wr_slot_q, cur_slot_q;
	logic                hist_vld_q  [MAX_GESTURE];
	logic [BORDER_W-1:0] hist_brd_q  [MAX_GESTURE];
	logic                hist_dir_q  [MAX_GESTURE];
	logic [TIME_W-1:0]   hist_time_q [MAX_GESTURE];

	logic [PAT_W-1:0]      pat_q [GESTURE_COUNT];
	logic [CFG_DATA_W-1:0] to_q  [GESTURE_COUNT];
	logic [CFG_IDX_W-2:0]  cfg_slot;

	logic [GW-1:0]       g_q;
	logic [HW-1:0]       i_q, addr_q;
	logic [PAT_W-1:0]    gpat_q;
	logic [TIME_W-1:0]   gto_q, prev_time_q;
	logic                ok_q;
	logic [MATCH_W-1:0]  match_q;
	logic [BORDER_W-1:0] out_border_q;
	logic [MATCH_W-1:0]  out_match_q;

	logic [LEN_W-1:0]    cfg_len;
	logic [SW-1:0]       start_raw;
	logic [HW-1:0]       start;
	logic [BORDER_W-1:0] code;
	logic [TIME_W-1:0]   e_time, gap;
	logic                fail;

	assign mid_x = DIFF_W'(left_q) + DIFF_W'(w_q[SIZE_W-1:1]);
	assign mid_y = DIFF_W'(top_q) + DIFF_W'(h_q[SIZE_W-1:1]);
	assign ax    = dx_q[DIFF_W-1] ? DIFF_W'(-dx_q) : DIFF_W'(dx_q);
	assign ay    = dy_q[DIFF_W-1] ? DIFF_W'(-dy_q) : DIFF_W'(dy_q);

	always_comb begin
		if (dx_q == '0) begin
			border_d = BORDER_RIGHT;
		end else if (dy_q[DIFF_W-1]) begin
			if (ay > ax) begin
				border_d = BORDER_TOP;
			end else begin
				border_d = dx_q[DIFF_W-1] ? BORDER_LEFT : BORDER_RIGHT;
			end
		end else if (ay > ax) begin
			border_d = BORDER_BOTTOM;
		end else if (dy_q == '0 || !dx_q[DIFF_W-1]) begin
			border_d = BORDER_RIGHT;
		end else begin
			border_d = BORDER_LEFT;
		end
	end

	assign cfg_len   = pat_q[g_q][LEN_LO +: LEN_W];
	assign start_raw = SW'(cur_slot_q) + SW'(MAX_GESTURE + 1) - SW'(cfg_len);
	assign start     = (start_raw >= SW'(MAX_GESTURE)) ?
		HW'(start_raw - SW'(MAX_GESTURE)) : HW'(start_raw);

	assign code   = gpat_q[{i_q, 1'b0} +: BORDER_W];
	assign e_time = hist_vld_q[addr_q] ? hist_time_q[addr_q] : '0;
	assign gap    = e_time - prev_time_q;

	always_comb begin
		fail = !hist_vld_q[addr_q] || (hist_brd_q[addr_q] != code);
		if (i_q == '0) begin
			if (hist_dir_q[addr_q] != gpat_q[DIR_BIT]) begin
				fail = 1'b1;
			end
		end else if (gto_q != '0 && gto_q < gap) begin
			fail = 1'b1;
		end
	end

	assign sts.len_ok    = (cfg_len != '0) && (cfg_len <= LEN_W'(MAX_GESTURE));
	assign sts.step_last = (LEN_W'(i_q) + LEN_W'(1)) == gpat_q[LEN_LO +: LEN_W];
	assign sts.gest_last = (g_q == GW'(GESTURE_COUNT - 1));

	assign cfg_slot = cfg_index[CFG_IDX_W-1:1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_slot_q <= '0;
			for (int k = 0; k < MAX_GESTURE; k++) begin
				hist_vld_q[k] <= 1'b0;
			end
			for (int k = 0; k < GESTURE_COUNT; k++) begin
				pat_q[k] <= '0;
				to_q[k]  <= '0;
			end
		end else begin
			if (cfg_we && cfg_index < CFG_IDX_W'(CFG_NUM_REGS)
			    && cfg_slot < (CFG_IDX_W-1)'(GESTURE_COUNT)) begin
				if (cfg_index[0] == CFG_KIND_PATTERN) begin
					pat_q[cfg_slot[GW-1:0]] <= cfg_data[PAT_W-1:0];
				end else begin
					to_q[cfg_slot[GW-1:0]] <= cfg_data;
				end
			end
			if (cmd.border) begin
				hist_vld_q[wr_slot_q] <= 1'b1;
				wr_slot_q <= (wr_slot_q == HW'(MAX_GESTURE - 1)) ? '0 : wr_slot_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			px_q   <= in_data[15:0];
			py_q   <= in_data[31:16];
			left_q <= in_data[47:32];
			top_q  <= in_data[63:48];
			w_q    <= in_data[78:64];
			h_q    <= in_data[93:79];
			time_q <= in_data[125:94];
			ent_q  <= in_user[0];
		end
		if (cmd.diff) begin
			dx_q <= DIFF_W'(px_q) - mid_x;
			dy_q <= DIFF_W'(py_q) - mid_y;
		end
		if (cmd.border) begin
			border_q                 <= border_d;
			hist_brd_q[wr_slot_q]    <= border_d;
			hist_dir_q[wr_slot_q]    <= ent_q;
			hist_time_q[wr_slot_q]   <= time_q;
			cur_slot_q               <= wr_slot_q;
			match_q                  <= '0;
			g_q                      <= '0;
		end
		if (cmd.ginit) begin
			gpat_q <= pat_q[g_q];
			gto_q  <= to_q[g_q];
			ok_q   <= sts.len_ok;
			i_q    <= '0;
			addr_q <= start;
		end
		if (cmd.walk) begin
			ok_q        <= ok_q & !fail;
			prev_time_q <= e_time;
			i_q         <= i_q + 1'b1;
			addr_q      <= (addr_q == HW'(MAX_GESTURE - 1)) ? '0 : addr_q + 1'b1;
		end
		if (cmd.gend) begin
			match_q[g_q] <= ok_q;
			g_q          <= g_q + 1'b1;
		end
		if (cmd.out_load) begin
			out_border_q <= border_q;
			out_match_q  <= match_q;
		end
	end

	assign out_data = {(OUT_TDATA_W - MATCH_W - BORDER_W)'(0), out_match_q, out_border_q};

endmodule
